// ===== hdl/tri2d_pkg.sv =====
// Shared types and constants for the three-anchor 2D trilateration block.
package tri2d_pkg;

	localparam int CoordW = 20;
	localparam int DistW  = 20;
	localparam int PosW   = 24;
	localparam int CfgIdxW = 3;
	localparam int RemW   = 64;
	localparam int DenW   = 44;
	localparam int QuoW   = PosW + 1;
	localparam int NumCells = QuoW;

	localparam logic [CfgIdxW-1:0] REG_A0X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_A0Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_A1X = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_A1Y = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_A2X = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_A2Y = 3'd5;

	localparam logic signed [CoordW-1:0] RST_A0X = 20'sd0;
	localparam logic signed [CoordW-1:0] RST_A0Y = 20'sd0;
	localparam logic signed [CoordW-1:0] RST_A1X = 20'sd500;
	localparam logic signed [CoordW-1:0] RST_A1Y = 20'sd0;
	localparam logic signed [CoordW-1:0] RST_A2X = 20'sd500;
	localparam logic signed [CoordW-1:0] RST_A2Y = 20'sd400;

	localparam logic signed [PosW-1:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [PosW-1:0] POS_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [CoordW-1:0] x0;
		logic signed [CoordW-1:0] y0;
		logic signed [CoordW-1:0] x1;
		logic signed [CoordW-1:0] y1;
		logic signed [CoordW-1:0] x2;
		logic signed [CoordW-1:0] y2;
	} anchors_t;

	// One slot of the divider chain: both coordinates share the divisor.
	typedef struct packed {
		logic            vld;
		logic            degen;
		logic            neg_x;
		logic            neg_y;
		logic [DenW-1:0] den;
		logic [RemW-1:0] rem_x;
		logic [RemW-1:0] rem_y;
		logic [QuoW-1:0] q_x;
		logic [QuoW-1:0] q_y;
	} div_t;

endpackage

// ===== hdl/tri2d_in_if.sv =====
// Input channel: one distance triple per transfer.
interface tri2d_in_if;
	logic                          valid;
	logic                          ready;
	logic [tri2d_pkg::DistW-1:0]   dist_a;
	logic [tri2d_pkg::DistW-1:0]   dist_b;
	logic [tri2d_pkg::DistW-1:0]   dist_c;

	modport source (output valid, dist_a, dist_b, dist_c, input ready);
	modport sink   (input valid, dist_a, dist_b, dist_c, output ready);
endinterface

// ===== hdl/tri2d_out_if.sv =====
// Output channel: one position estimate per transfer.
interface tri2d_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [tri2d_pkg::PosW-1:0]  pos_x;
	logic signed [tri2d_pkg::PosW-1:0]  pos_y;
	logic                               degenerate;
	logic                               overflow;

	modport source (output valid, pos_x, pos_y, degenerate, overflow, input ready);
	modport sink   (input valid, pos_x, pos_y, degenerate, overflow, output ready);
endinterface

// ===== hdl/tri2d_front.sv =====
// Front end: linear system coefficients, Cramer numerators and determinant, sign split.
module tri2d_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [tri2d_pkg::DistW-1:0]  dist_a,
	input  logic [tri2d_pkg::DistW-1:0]  dist_b,
	input  logic [tri2d_pkg::DistW-1:0]  dist_c,
	input  tri2d_pkg::anchors_t          anc,
	output tri2d_pkg::div_t              d_out
);
	import tri2d_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: squares and coefficient differences
	logic        [39:0] da2_s1, db2_s1, dc2_s1;
	logic        [38:0] sx0_s1, sy0_s1, sx1_s1, sy1_s1, sx2_s1, sy2_s1;
	logic signed [21:0] a_s1, b_s1, d_s1, e_s1;
	logic signed [20:0] dx10, dy10, dx21, dy21;
	logic signed [39:0] qx0, qy0, qx1, qy1, qx2, qy2;

	assign dx10 = 21'(anc.x1) - 21'(anc.x0);
	assign dy10 = 21'(anc.y1) - 21'(anc.y0);
	assign dx21 = 21'(anc.x2) - 21'(anc.x1);
	assign dy21 = 21'(anc.y2) - 21'(anc.y1);
	assign qx0 = anc.x0 * anc.x0;
	assign qy0 = anc.y0 * anc.y0;
	assign qx1 = anc.x1 * anc.x1;
	assign qy1 = anc.y1 * anc.y1;
	assign qx2 = anc.x2 * anc.x2;
	assign qy2 = anc.y2 * anc.y2;

	always_ff @(posedge clk) begin
		if (en) begin
			da2_s1 <= dist_a * dist_a;
			db2_s1 <= dist_b * dist_b;
			dc2_s1 <= dist_c * dist_c;
			sx0_s1 <= qx0[38:0];
			sy0_s1 <= qy0[38:0];
			sx1_s1 <= qx1[38:0];
			sy1_s1 <= qy1[38:0];
			sx2_s1 <= qx2[38:0];
			sy2_s1 <= qy2[38:0];
			a_s1   <= {dx10, 1'b0};
			b_s1   <= {dy10, 1'b0};
			d_s1   <= {dx21, 1'b0};
			e_s1   <= {dy21, 1'b0};
		end
	end

	// stage 2: right-hand sides and determinant products
	logic signed [42:0] c_s2, f_s2;
	logic signed [43:0] ae_s2, bd_s2;
	logic signed [21:0] a_s2, b_s2, d_s2, e_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2  <= 43'(da2_s1) - 43'(db2_s1) - 43'(sx0_s1) + 43'(sx1_s1)
				- 43'(sy0_s1) + 43'(sy1_s1);
			f_s2  <= 43'(db2_s1) - 43'(dc2_s1) - 43'(sx1_s1) + 43'(sx2_s1)
				- 43'(sy1_s1) + 43'(sy2_s1);
			ae_s2 <= a_s1 * e_s1;
			bd_s2 <= b_s1 * d_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			d_s2  <= d_s1;
			e_s2  <= e_s1;
		end
	end

	// stage 3: numerator partial products, c and f split at bit 21
	logic signed [21:0] ch, fh, cl, fl;
	logic signed [43:0] det_s3;
	logic signed [43:0] che_s3, cle_s3, fhb_s3, flb_s3;
	logic signed [43:0] fha_s3, fla_s3, chd_s3, cld_s3;

	assign ch = c_s2[42:21];
	assign fh = f_s2[42:21];
	assign cl = $signed({1'b0, c_s2[20:0]});
	assign fl = $signed({1'b0, f_s2[20:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= ae_s2 - bd_s2;
			che_s3 <= ch * e_s2;
			cle_s3 <= cl * e_s2;
			fhb_s3 <= fh * b_s2;
			flb_s3 <= fl * b_s2;
			fha_s3 <= fh * a_s2;
			fla_s3 <= fl * a_s2;
			chd_s3 <= ch * d_s2;
			cld_s3 <= cl * d_s2;
		end
	end

	// stage 4: full numerators
	logic signed [63:0] nx_s4, ny_s4;
	logic signed [43:0] det_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4  <= (64'(che_s3) <<< 21) + 64'(cle_s3)
				- (64'(fhb_s3) <<< 21) - 64'(flb_s3);
			ny_s4  <= (64'(fha_s3) <<< 21) + 64'(fla_s3)
				- (64'(chd_s3) <<< 21) - 64'(cld_s3);
			det_s4 <= det_s3;
		end
	end

	// stage 5: magnitudes and quotient signs into the divider chain
	logic [63:0] mag_x, mag_y;
	logic [43:0] mag_d;

	assign mag_x = nx_s4[63] ? 64'(-nx_s4) : 64'(nx_s4);
	assign mag_y = ny_s4[63] ? 64'(-ny_s4) : 64'(ny_s4);
	assign mag_d = det_s4[43] ? 44'(-det_s4) : 44'(det_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out.vld   <= v_s4;
			d_out.degen <= (det_s4 == '0);
			d_out.neg_x <= nx_s4[63] ^ det_s4[43];
			d_out.neg_y <= ny_s4[63] ^ det_s4[43];
			d_out.den   <= mag_d;
			d_out.rem_x <= mag_x;
			d_out.rem_y <= mag_y;
			d_out.q_x   <= '0;
			d_out.q_y   <= '0;
		end
	end

endmodule

// ===== hdl/tri2d_cell.sv =====
// One restoring-division cell: settles quotient bit BIT of both coordinates.
module tri2d_cell #(
	parameter int BIT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tri2d_pkg::div_t  d_in,
	output tri2d_pkg::div_t  d_out
);
	import tri2d_pkg::*;

	localparam int TrialW = RemW + 5;

	logic [TrialW-1:0] dsh, tx, ty;

	assign dsh = TrialW'(d_in.den) << BIT;
	assign tx  = TrialW'(d_in.rem_x) - dsh;
	assign ty  = TrialW'(d_in.rem_y) - dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out.vld   <= d_in.vld;
			d_out.degen <= d_in.degen;
			d_out.neg_x <= d_in.neg_x;
			d_out.neg_y <= d_in.neg_y;
			d_out.den   <= d_in.den;
			d_out.rem_x <= tx[TrialW-1] ? d_in.rem_x : tx[RemW-1:0];
			d_out.rem_y <= ty[TrialW-1] ? d_in.rem_y : ty[RemW-1:0];
			d_out.q_x   <= d_in.q_x | (QuoW'(!tx[TrialW-1]) << BIT);
			d_out.q_y   <= d_in.q_y | (QuoW'(!ty[TrialW-1]) << BIT);
		end
	end

endmodule

// ===== hdl/trilateration_2d_three_anchor.sv =====
// Top level: anchor registers, front end, divider cell chain and output register.
//
// Computes a planar position from three ranges (inp: dist_a, dist_b, dist_c,
// unsigned cm) to three anchors held in six 20-bit signed registers, written
// through cfg_we / cfg_idx / cfg_data (index 0..5 = a0x, a0y, a1x, a1y, a2x,
// a2y; higher indexes are ignored). Write registers only while no item is in
// flight. Results leave on res as pos_x, pos_y (24-bit signed cm, truncated
// toward zero and saturated), degenerate (collinear anchors, position zero)
// and overflow (a coordinate was clamped).
// Results pass through five front-end stages, 25 division cells (one quotient
// bit each) and the output register. Throughput is one triple per cycle while
// the receiver accepts results; the whole pipeline advances together.
// When the receiver stalls with a result waiting, every stage holds and
// inp.ready drops in the same cycle.
// Reset clears all valid bits and loads the anchors with their default
// layout (0,0), (500,0), (500,400).
module trilateration_2d_three_anchor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	tri2d_in_if.sink                              inp,
	tri2d_out_if.source                           res,
	input  logic                                  cfg_we,
	input  logic [tri2d_pkg::CfgIdxW-1:0]         cfg_idx,
	input  logic [tri2d_pkg::CoordW-1:0]          cfg_data
);
	import tri2d_pkg::*;

	anchors_t anc_q;
	logic     adv;
	div_t     chain [0:NumCells];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anc_q.x0 <= RST_A0X;
			anc_q.y0 <= RST_A0Y;
			anc_q.x1 <= RST_A1X;
			anc_q.y1 <= RST_A1Y;
			anc_q.x2 <= RST_A2X;
			anc_q.y2 <= RST_A2Y;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_A0X: anc_q.x0 <= cfg_data;
				REG_A0Y: anc_q.y0 <= cfg_data;
				REG_A1X: anc_q.x1 <= cfg_data;
				REG_A1Y: anc_q.y1 <= cfg_data;
				REG_A2X: anc_q.x2 <= cfg_data;
				REG_A2Y: anc_q.y2 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv       = !res.valid || res.ready;
	assign inp.ready = adv;

	tri2d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_vld (inp.valid),
		.dist_a (inp.dist_a),
		.dist_b (inp.dist_b),
		.dist_c (inp.dist_c),
		.anc    (anc_q),
		.d_out  (chain[0])
	);

	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		tri2d_cell #(.BIT(NumCells - 1 - k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d_in   (chain[k]),
			.d_out  (chain[k+1])
		);
	end

	// saturation: quotient magnitude is exact below 2^24, bit 24 means far out of range
	div_t              fin;
	logic              big_x, big_y;
	logic [PosW-1:0]   px, py;

	assign fin   = chain[NumCells];
	assign big_x = fin.q_x[PosW] || (!fin.neg_x && fin.q_x[PosW-1])
		|| (fin.neg_x && fin.q_x[PosW-1] && (|fin.q_x[PosW-2:0]));
	assign big_y = fin.q_y[PosW] || (!fin.neg_y && fin.q_y[PosW-1])
		|| (fin.neg_y && fin.q_y[PosW-1] && (|fin.q_y[PosW-2:0]));

	always_comb begin
		if (big_x) px = fin.neg_x ? POS_MIN : POS_MAX;
		else       px = fin.neg_x ? PosW'(-fin.q_x[PosW-1:0]) : fin.q_x[PosW-1:0];
		if (big_y) py = fin.neg_y ? POS_MIN : POS_MAX;
		else       py = fin.neg_y ? PosW'(-fin.q_y[PosW-1:0]) : fin.q_y[PosW-1:0];
	end

	logic              vld_q;
	logic [PosW-1:0]   pos_x_q, pos_y_q;
	logic              degen_q, ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_x_q <= fin.degen ? '0 : px;
			pos_y_q <= fin.degen ? '0 : py;
			degen_q <= fin.degen;
			ovf_q   <= !fin.degen && (big_x || big_y);
		end
	end

	assign res.valid      = vld_q;
	assign res.pos_x      = pos_x_q;
	assign res.pos_y      = pos_y_q;
	assign res.degenerate = degen_q;
	assign res.overflow   = ovf_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.degenerate |-> res.pos_x == '0 && res.pos_y == '0 && !res.overflow)
		else $error("degenerate result with nonzero position or overflow");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.overflow |-> res.pos_x == POS_MAX || res.pos_x == POS_MIN
			|| res.pos_y == POS_MAX || res.pos_y == POS_MIN)
		else $error("overflow flagged without a saturated coordinate");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(chain[0]) && $stable(chain[NumCells]))
		else $error("pipeline moved during a stall");

endmodule
